### design/nli_pkg.sv
// ----------------------------------------------------------------------------
// nli_pkg: shared constants of the Neville interpolator
// Field widths, internal word widths and divider stepping that the top level,
// the divider and the multiplier all rely on.
// ----------------------------------------------------------------------------
package nli_pkg;

  // Payload field widths.
  localparam int SMP_W       = 32;  // sample and result, signed Q8.24
  localparam int POS_W       = 21;  // query position, unsigned Q5.16
  localparam int IN_TDATA_W  = 56;  // sample, position, zero pad to bytes
  localparam int OUT_TDATA_W = 32;  // interpolated value

  // Correction columns are signed Q24.24 words.
  localparam int CORR_W = 48;

  // Divider word: magnitude of a column difference plus rounding offset.
  localparam int DIV_W    = 50;
  localparam int DIV_STEP = 2;      // quotient bits resolved per cycle

  // The multiplier splits its wide operand into two halves.
  localparam int HALF_W = DIV_W / 2;

  // Products are taken in Q.16 and rounded back by this many bits.
  localparam int FRAC_SH = 16;

endpackage

### design/nli_ram.sv
// ----------------------------------------------------------------------------
// nli_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module nli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/nli_div.sv
// ----------------------------------------------------------------------------
// nli_div: iterative divider by a small negated order
// Computes round(w / -m), half away from zero, by long division of |w| + m/2,
// resolving DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module nli_div
  import nli_pkg::*;
#(
  parameter int M_W = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [CORR_W:0]  w,
  input  logic [M_W-1:0]          m,
  output logic                    done,
  output logic signed [DIV_W-1:0] den
);

  localparam int ITERS = DIV_W / DIV_STEP;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [DIV_W-1:0] num_r, num_nxt;
  logic [M_W-1:0]   rem_r, rem_nxt;
  logic [M_W-1:0]   m_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;

  logic             w_neg;
  logic [CORR_W:0]  w_mag;
  logic [DIV_W-1:0] numer;

  assign w_neg = w[CORR_W];
  assign w_mag = w_neg ? (CORR_W + 1)'(-w) : (CORR_W + 1)'(w);
  assign numer = DIV_W'(w_mag) + DIV_W'(m >> 1);

  // Restoring long division; the remainder always stays below the divisor.
  always_comb begin
    logic [M_W:0] trial;
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int s = 0; s < DIV_STEP; s++) begin
      trial   = {rem_nxt, num_nxt[DIV_W-1]};
      num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, m_r}) begin
        trial      = trial - {1'b0, m_r};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = trial[M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      rem_r <= '0;
      m_r   <= m;
      neg_r <= w_neg;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // The quotient holds after completion until the next start.
  assign den  = neg_r ? $signed(num_r) : -$signed(num_r);
  assign done = done_r;

endmodule

### design/nli_mul.sv
// ----------------------------------------------------------------------------
// nli_mul: shared Q.16 product unit
// Forms (a * h) >> 16, rounded half away from zero and saturated to a
// correction word, from two partial products of a half-width multiplier.
// ----------------------------------------------------------------------------
module nli_mul
  import nli_pkg::*;
#(
  parameter int H_W = 22
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIV_W-1:0]  a,
  input  logic signed [H_W-1:0]    h,
  output logic                     done,
  output logic signed [CORR_W-1:0] prod
);

  localparam int UH_W  = H_W - 1;
  localparam int PP_W  = HALF_W + UH_W;
  localparam int ACC_W = DIV_W + UH_W;
  localparam int R_W   = ACC_W + 1 - FRAC_SH;

  localparam logic [ACC_W:0]         RND_HALF = (ACC_W + 1)'(1) << (FRAC_SH - 1);
  localparam logic signed [CORR_W-1:0] MAX_C  = {1'b0, {(CORR_W - 1){1'b1}}};
  localparam logic signed [CORR_W-1:0] MIN_C  = {1'b1, {(CORR_W - 1){1'b0}}};

  logic [DIV_W-1:0] ua_r;
  logic [UH_W-1:0]  uh_r;
  logic             neg_r;
  logic [PP_W-1:0]  pp_r;
  logic [ACC_W-1:0] acc_r;
  logic [1:0]       phase_r;
  logic             busy_r;
  logic             done_r;
  logic signed [CORR_W-1:0] prod_r;

  logic [HALF_W-1:0] half_op;
  logic [PP_W-1:0]   pp_now;
  logic [ACC_W:0]    rounded;
  logic [R_W-1:0]    mag;
  logic              too_big;
  logic signed [CORR_W-1:0] result;

  // Low half in the first phase, high half in the second.
  assign half_op = (phase_r == 2'd0) ? ua_r[HALF_W-1:0] : ua_r[DIV_W-1:HALF_W];
  assign pp_now  = PP_W'(half_op) * PP_W'(uh_r);

  assign rounded = (ACC_W + 1)'(acc_r) + RND_HALF;
  assign mag     = rounded[ACC_W:FRAC_SH];
  assign too_big = |mag[R_W-1:CORR_W-1];

  always_comb begin
    if (too_big) begin
      result = neg_r ? MIN_C : MAX_C;
    end else if (neg_r) begin
      result = -$signed({1'b0, mag[CORR_W-2:0]});
    end else begin
      result = $signed({1'b0, mag[CORR_W-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= a[DIV_W-1] ? DIV_W'(-a) : DIV_W'(a);
      uh_r  <= h[H_W-1] ? UH_W'(-h) : UH_W'(h);
      neg_r <= a[DIV_W-1] ^ h[H_W-1];
    end else if (busy_r) begin
      unique case (phase_r)
        2'd0: pp_r <= pp_now;
        2'd1: begin
          acc_r <= ACC_W'(pp_r);
          pp_r  <= pp_now;
        end
        2'd2: acc_r <= acc_r + (ACC_W'(pp_r) << HALF_W);
        2'd3: prod_r <= result;
        default: pp_r <= pp_r;
      endcase
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

### design/neville_lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// neville_lagrange_interpolator: Neville polynomial interpolation
// Loads a window of samples at nodes 1..WINDOW and evaluates the polynomial
// through them at a query position with Neville's recurrence.
// ----------------------------------------------------------------------------
// Usage. Each input word carries one signed Q8.24 sample in in_tdata; it is
// stored at the next node, and words beyond WINDOW are dropped. The word
// with in_tlast set also carries the Q5.16 query position and starts an
// evaluation; one result word (value and clip flag) then leaves on out_*.
// Sample words are taken one per cycle. After the last word the block is
// busy until the result is offered. The evaluation time is set by the
// shared divider, which resolves two quotient bits per cycle, and the
// shared multiplier, which forms each correction from two partial products;
// the divider serves once and the multiplier twice in each of the
// W*(W-1)/2 recurrence steps (W = WINDOW). in_tready is low during evaluation.
// The result sits in an output register, so a new window may be loaded while
// the receiver stalls; a finished evaluation waits until that register is
// free. Reset empties the window count and the output register; the sample
// store and the correction columns hold no defined value until written.
// ----------------------------------------------------------------------------
module neville_lagrange_interpolator
  import nli_pkg::*;
#(
  parameter int SEMI_WINDOW = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample_value, [52:32] query_position
  input  logic                   in_tlast,   // last_sample
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] interpolated_value
  output logic                   out_tuser   // [0] saturated
);

  localparam int WINDOW = 2 * SEMI_WINDOW;
  localparam int KW     = $clog2(WINDOW);
  localparam int LCW    = $clog2(WINDOW + 1);
  localparam int NODE_W = $clog2(WINDOW + 1) + FRAC_SH;
  localparam int H_W    = ((NODE_W > POS_W) ? NODE_W : POS_W) + 1;
  localparam int ACC_W  = CORR_W + KW + 1;

  localparam logic [KW-1:0] LAST_IDX = KW'(WINDOW - 1);
  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'($signed(32'h7FFF_FFFF));
  localparam logic signed [ACC_W-1:0] RES_MIN = ACC_W'($signed(32'h8000_0000));

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_LOAD    = 10'b00_0000_0001,
    S_INIT_RD = 10'b00_0000_0010,
    S_INIT_WR = 10'b00_0000_0100,
    S_RD      = 10'b00_0000_1000,
    S_DIV_GO  = 10'b00_0001_0000,
    S_DIV     = 10'b00_0010_0000,
    S_MUL_D   = 10'b00_0100_0000,
    S_MUL_C   = 10'b00_1000_0000,
    S_ACC_RD  = 10'b01_0000_0000,
    S_ACC     = 10'b10_0000_0000
  } seq_state_t;

  // The emit step shares the accumulate state's code; emit_r tells the two apart.
  localparam seq_state_t S_EMIT_CODE = S_ACC;

  function automatic logic [NODE_W-1:0] node_of(input logic [KW-1:0] k);
    node_of = NODE_W'({1'b0, k} + (KW + 1)'(1)) << FRAC_SH;
  endfunction

  seq_state_t state_r, state_nxt;
  logic             emit_r, emit_nxt;
  logic [LCW-1:0]   load_cnt_r, load_cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [KW-1:0]    idx_r, idx_nxt;
  logic [KW-1:0]    ord_r, ord_nxt;
  logic [KW-1:0]    ns_r, ns_nxt;
  logic [H_W-1:0]   best_r, best_nxt;
  logic signed [ACC_W-1:0] res_r, res_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [SMP_W-1:0] out_data_r, out_data_nxt;
  logic             out_sat_r, out_sat_nxt;

  // Memory ports.
  logic              smp_we;
  logic [SMP_W-1:0]  smp_rdata;
  logic              c_we, d_we;
  logic [KW-1:0]     c_raddr, d_raddr;
  logic [CORR_W-1:0] c_wdata, d_wdata;
  logic [CORR_W-1:0] c_rdata, d_rdata;

  // Shared units.
  logic                     div_start, div_done;
  logic signed [CORR_W:0]   diff_w;
  logic signed [DIV_W-1:0]  div_den;
  logic                     mul_start, mul_done;
  logic signed [H_W-1:0]    mul_h;
  logic signed [CORR_W-1:0] mul_prod;

  // Offsets of the current nodes from the query position.
  logic signed [H_W-1:0] h_lo, h_hi;
  logic [H_W-1:0]        node_gap;
  logic [KW-1:0]         last_i;
  logic                  take_upper;
  logic                  in_acc;
  logic                  out_free;
  logic                  sat_hi, sat_lo;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  assign h_lo     = $signed(H_W'(node_of(idx_r))) - $signed(H_W'(pos_r));
  assign h_hi     = $signed(H_W'(node_of(idx_r + ord_r))) - $signed(H_W'(pos_r));
  assign node_gap = h_lo[H_W-1] ? H_W'(-h_lo) : H_W'(h_lo);

  assign last_i = LAST_IDX - ord_r;

  // Take the upper correction while the start node sits in the lower half.
  assign take_upper = {ns_r, 1'b0} < ((KW + 1)'(WINDOW) - {1'b0, ord_r});

  assign c_raddr = (state_r == S_ACC_RD) ? ns_r : idx_r + KW'(1);
  assign d_raddr = (state_r == S_ACC_RD) ? ns_r - KW'(1) : idx_r;

  assign diff_w = (CORR_W + 1)'($signed(c_rdata)) - (CORR_W + 1)'($signed(d_rdata));
  assign mul_h  = (state_r == S_DIV) ? h_hi : h_lo;

  assign sat_hi = res_r > RES_MAX;
  assign sat_lo = res_r < RES_MIN;

  always_comb begin
    state_nxt      = state_r;
    emit_nxt       = emit_r;
    load_cnt_nxt   = load_cnt_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    ord_nxt        = ord_r;
    ns_nxt         = ns_r;
    best_nxt       = best_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_sat_nxt    = out_sat_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    smp_we         = 1'b0;
    c_we           = 1'b0;
    d_we           = 1'b0;
    c_wdata        = mul_prod;
    d_wdata        = mul_prod;
    div_start      = 1'b0;
    mul_start      = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_r < LCW'(WINDOW)) begin
            smp_we       = 1'b1;
            load_cnt_nxt = load_cnt_r + LCW'(1);
          end
          if (in_tlast) begin
            load_cnt_nxt = '0;
            pos_nxt      = in_tdata[SMP_W +: POS_W];
            idx_nxt      = '0;
            state_nxt    = S_INIT_RD;
          end
        end
      end

      S_INIT_RD: state_nxt = S_INIT_WR;

      // Copy a sample into both columns and track the nearest node; the
      // first node that reaches the minimum distance is kept.
      S_INIT_WR: begin
        c_we    = 1'b1;
        d_we    = 1'b1;
        c_wdata = CORR_W'($signed(smp_rdata));
        d_wdata = CORR_W'($signed(smp_rdata));
        if (idx_r == '0 || node_gap < best_r) begin
          best_nxt = node_gap;
          ns_nxt   = idx_r;
          res_nxt  = ACC_W'($signed(smp_rdata));
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          ord_nxt   = KW'(1);
          state_nxt = S_RD;
        end else begin
          idx_nxt   = idx_r + KW'(1);
          state_nxt = S_INIT_RD;
        end
      end

      S_RD: state_nxt = S_DIV_GO;

      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end

      // Lower correction first: den times the offset of the far node.
      S_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = S_MUL_D;
        end
      end

      S_MUL_D: begin
        if (mul_done) begin
          d_we      = 1'b1;
          mul_start = 1'b1;
          state_nxt = S_MUL_C;
        end
      end

      S_MUL_C: begin
        if (mul_done) begin
          c_we = 1'b1;
          if (idx_r == last_i) begin
            state_nxt = S_ACC_RD;
          end else begin
            idx_nxt   = idx_r + KW'(1);
            state_nxt = S_RD;
          end
        end
      end

      S_ACC_RD: state_nxt = S_ACC;

      // Add this order's correction; stepping down the lower column moves
      // the path one node to the left.
      S_ACC: begin
        if (emit_r) begin
          if (out_free) begin
            out_tvalid_nxt = 1'b1;
            out_data_nxt   = sat_hi ? 32'h7FFF_FFFF :
                             sat_lo ? 32'h8000_0000 : res_r[SMP_W-1:0];
            out_sat_nxt    = sat_hi || sat_lo;
            emit_nxt       = 1'b0;
            state_nxt      = S_LOAD;
          end
        end else begin
          res_nxt = res_r + (take_upper ? ACC_W'($signed(c_rdata))
                                        : ACC_W'($signed(d_rdata)));
          if (!take_upper) begin
            ns_nxt = ns_r - KW'(1);
          end
          if (ord_r == LAST_IDX) begin
            emit_nxt  = 1'b1;
            state_nxt = S_EMIT_CODE;
          end else begin
            ord_nxt   = ord_r + KW'(1);
            idx_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      emit_r       <= 1'b0;
      load_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      emit_r       <= emit_nxt;
      load_cnt_r   <= load_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    ord_r      <= ord_nxt;
    ns_r       <= ns_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  nli_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (load_cnt_r[KW-1:0]),
    .wdata (in_tdata[SMP_W-1:0]),
    .raddr (idx_r),
    .rdata (smp_rdata)
  );

  nli_ram #(
    .WIDTH (CORR_W),
    .DEPTH (WINDOW)
  ) u_upper_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (idx_r),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  nli_ram #(
    .WIDTH (CORR_W),
    .DEPTH (WINDOW)
  ) u_lower_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (idx_r),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  nli_div #(
    .M_W (KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .w     (diff_w),
    .m     (ord_r),
    .done  (div_done),
    .den   (div_den)
  );

  // The divider holds its quotient, so both products read it directly.
  nli_mul #(
    .H_W (H_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (div_den),
    .h     (mul_h),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule
